### hdl/psfg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psfg_pkg
// Shared types, constants and the fringe table function for the
// phase-shift fringe generator.
// ----------------------------------------------------------------------------
package psfg_pkg;

   localparam int PHASE_BITS     = 16;
   localparam int PIXEL_BITS     = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int EFF_BITS       = 17;
   localparam int FIFO_DEPTH     = 4;
   localparam int FIFO_PTR_BITS  = 2;
   localparam int FIFO_CNT_BITS  = 3;

   localparam logic [PHASE_BITS-1:0] PHASE_HALF = 16'h8000;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PERIOD_PIXELS   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_INCREMENT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHIFT_INDEX     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHIFT_COUNT     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHIFT_STEP      = 3'd4;

   localparam logic [12:0] RST_PERIOD_PIXELS   = 13'd16;
   localparam logic [15:0] RST_PHASE_INCREMENT = 16'd4096;
   localparam logic [7:0]  RST_SHIFT_INDEX     = 8'd1;
   localparam logic [7:0]  RST_SHIFT_COUNT     = 8'd4;
   localparam logic [15:0] RST_SHIFT_STEP      = 16'd16384;

   localparam longint ONE_Q30    = 64'sd1 << 30;
   localparam longint TWO_PI_Q32 = 64'sd26986075410;

   typedef struct packed {
      logic [EFF_BITS-1:0]   period_eff;
      logic [PHASE_BITS-1:0] phase_increment;
      logic [PHASE_BITS-1:0] phase_offset;
      logic                  suppress;
   } psfg_cfg_type;

   // cos of x/65536 turns, x in 0..16384, Q30, Horner series
   function automatic longint quarter_cos(input longint x);
      longint t;
      longint u;
      longint h;
      t = (x * TWO_PI_Q32) >>> 18;
      u = (t * t) >>> 30;
      h = ONE_Q30 - u / 132;
      h = ONE_Q30 - ((u * h) >>> 30) / 90;
      h = ONE_Q30 - ((u * h) >>> 30) / 56;
      h = ONE_Q30 - ((u * h) >>> 30) / 30;
      h = ONE_Q30 - ((u * h) >>> 30) / 12;
      h = ONE_Q30 - ((u * h) >>> 30) / 2;
      if (h < 0) h = 0;
      if (h > ONE_Q30) h = ONE_Q30;
      return h;
   endfunction

   // pixel for table entry idx of a 2^table_bits entry table
   function automatic logic [PIXEL_BITS-1:0] fringe_pixel(input int table_bits,
                                                           input int idx);
      longint q;
      longint quad;
      longint r;
      longint c;
      longint v;
      q    = longint'(idx) << (PHASE_BITS - table_bits);
      quad = (q >>> 14) & 3;
      r    = q & 16'h3FFF;
      if (quad == 0) c = quarter_cos(r);
      else if (quad == 1) c = -quarter_cos(16384 - r);
      else if (quad == 2) c = -quarter_cos(r);
      else c = quarter_cos(16384 - r);
      v = (100 * (ONE_Q30 + c)) >>> 30;
      return v[PIXEL_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

### hdl/psfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psfg channel interfaces
// Request, response and register-write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface psfg_req_if;
   logic valid;
   logic ready;
   logic line_start;
   logic line_end;
   modport source (output valid, line_start, line_end, input ready);
   modport sink   (input valid, line_start, line_end, output ready);
endinterface

interface psfg_rsp_if import psfg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_value;
   logic                  last_pixel;
   modport source (output valid, pixel_value, last_pixel, input ready);
   modport sink   (input valid, pixel_value, last_pixel, output ready);
endinterface

interface psfg_csr_if import psfg_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/psfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psfg_regs
// Configuration registers and the values derived from them
// (effective period, pattern phase offset, suppress flag).
// ----------------------------------------------------------------------------
module psfg_regs import psfg_pkg::*; #(
   parameter int PERIOD_BITS = 12
) (
   input  wire logic   clock,
   input  wire logic   reset,
   psfg_csr_if.sink    csr_if,
   output psfg_cfg_type cfg
);

   logic [12:0] period_pixels_ff, period_pixels_in;
   logic [15:0] phase_increment_ff, phase_increment_in;
   logic [7:0]  shift_index_ff, shift_index_in;
   logic [7:0]  shift_count_ff, shift_count_in;
   logic [15:0] shift_step_ff, shift_step_in;
   psfg_cfg_type cfg_ff, cfg_in;

   logic                  wr;
   logic [EFF_BITS-1:0]   period_ext;
   logic [EFF_BITS-1:0]   period_limit;
   logic [15:0]           step_product;

   assign csr_if.ready = 1'b1;
   assign wr = csr_if.valid;

   always_comb begin
      period_pixels_in   = period_pixels_ff;
      phase_increment_in = phase_increment_ff;
      shift_index_in     = shift_index_ff;
      shift_count_in     = shift_count_ff;
      shift_step_in      = shift_step_ff;
      if (wr) begin
         unique case (csr_if.index)
            CSR_PERIOD_PIXELS:   period_pixels_in   = csr_if.data[12:0];
            CSR_PHASE_INCREMENT: phase_increment_in = csr_if.data;
            CSR_SHIFT_INDEX:     shift_index_in     = csr_if.data[7:0];
            CSR_SHIFT_COUNT:     shift_count_in     = csr_if.data[7:0];
            CSR_SHIFT_STEP:      shift_step_in      = csr_if.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      period_ext   = EFF_BITS'(period_pixels_in);
      period_limit = EFF_BITS'(1) << PERIOD_BITS;
      step_product = 16'(shift_index_in) * shift_step_in;
      cfg_in.phase_increment = phase_increment_in;
      cfg_in.phase_offset    = step_product - shift_step_in;
      cfg_in.suppress        = (shift_index_in > shift_count_in);
      if (period_ext == '0) begin
         cfg_in.period_eff = EFF_BITS'(1);
      end else if (period_ext > period_limit) begin
         cfg_in.period_eff = period_limit;
      end else begin
         cfg_in.period_eff = period_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_pixels_ff       <= RST_PERIOD_PIXELS;
         phase_increment_ff     <= RST_PHASE_INCREMENT;
         shift_index_ff         <= RST_SHIFT_INDEX;
         shift_count_ff         <= RST_SHIFT_COUNT;
         shift_step_ff          <= RST_SHIFT_STEP;
         cfg_ff.period_eff      <= EFF_BITS'(RST_PERIOD_PIXELS);
         cfg_ff.phase_increment <= RST_PHASE_INCREMENT;
         cfg_ff.phase_offset    <= '0;
         cfg_ff.suppress        <= 1'b0;
      end else begin
         period_pixels_ff   <= period_pixels_in;
         phase_increment_ff <= phase_increment_in;
         shift_index_ff     <= shift_index_in;
         shift_count_ff     <= shift_count_in;
         shift_step_ff      <= shift_step_in;
         cfg_ff             <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

### hdl/psfg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psfg_front
// Accepts request words, drops them for a suppressed pattern, tracks the
// period position and phase, and pushes the table index into the queue.
// ----------------------------------------------------------------------------
module psfg_front import psfg_pkg::*; #(
   parameter int TABLE_BITS  = 10,
   parameter int PERIOD_BITS = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   psfg_req_if.sink                   req_if,
   input  wire psfg_cfg_type          cfg,
   input  wire logic                  push_ready,
   output logic                       push_valid,
   output logic [TABLE_BITS:0]        push_data
);

   logic [PERIOD_BITS-1:0] position_ff, position_in;
   logic [PHASE_BITS-1:0]  accum_ff, accum_in;

   logic                   take;
   logic [PERIOD_BITS-1:0] cur_position;
   logic [PHASE_BITS-1:0]  cur_accum;
   logic [PHASE_BITS-1:0]  phase;
   logic [EFF_BITS-1:0]    position_next;

   assign req_if.ready = push_ready;
   assign take         = req_if.valid && push_ready && !cfg.suppress;
   assign push_valid   = take;

   always_comb begin
      cur_position  = req_if.line_start ? '0 : position_ff;
      cur_accum     = req_if.line_start ? '0 : accum_ff;
      phase         = PHASE_HALF + cur_accum - cfg.phase_offset;
      push_data     = {phase[PHASE_BITS-1 -: TABLE_BITS], req_if.line_end};
      position_next = EFF_BITS'(cur_position) + EFF_BITS'(1);
      position_in   = position_ff;
      accum_in      = accum_ff;
      if (take) begin
         if (position_next >= cfg.period_eff) begin
            position_in = '0;
            accum_in    = '0;
         end else begin
            position_in = position_next[PERIOD_BITS-1:0];
            accum_in    = cur_accum + cfg.phase_increment;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         accum_ff    <= '0;
      end else begin
         position_ff <= position_in;
         accum_ff    <= accum_in;
      end
   end

endmodule
`default_nettype wire

### hdl/psfg_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psfg_fifo
// Short queue between front and back.
// ----------------------------------------------------------------------------
module psfg_fifo import psfg_pkg::*; #(
   parameter int WIDTH = 11
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   logic [WIDTH-1:0]         mem [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   assign push_ready = (count_ff != FIFO_CNT_BITS'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + FIFO_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + FIFO_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + FIFO_CNT_BITS'(1);
      else if (do_pop && !do_push) count_in = count_ff - FIFO_CNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

### hdl/psfg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psfg_back
// Fringe table lookup (registered ROM read) and the response register.
// ----------------------------------------------------------------------------
module psfg_back import psfg_pkg::*; #(
   parameter int TABLE_BITS = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pop_valid,
   output logic                   pop_ready,
   input  wire logic [TABLE_BITS:0] pop_data,
   psfg_rsp_if.source             rsp_if
);

   localparam int ROM_DEPTH = 1 << TABLE_BITS;

   typedef logic [PIXEL_BITS-1:0] rom_type [ROM_DEPTH];

   function automatic rom_type build_rom();
      rom_type r;
      for (int i = 0; i < ROM_DEPTH; i++) begin
         r[i] = fringe_pixel(TABLE_BITS, i);
      end
      return r;
   endfunction

   localparam rom_type FRINGE_ROM = build_rom();

   logic [PIXEL_BITS-1:0] rom_data_ff;
   logic                  s1_last_ff;
   logic                  s1_valid_ff, s1_valid_in;
   logic [PIXEL_BITS-1:0] pixel_ff;
   logic                  last_ff;
   logic                  out_valid_ff, out_valid_in;
   logic                  s1_adv;
   logic                  pop;

   assign s1_adv    = s1_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign pop_ready = !s1_valid_ff || s1_adv;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      s1_valid_in  = pop ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_adv ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rom_data_ff <= FRINGE_ROM[pop_data[TABLE_BITS:1]];
         s1_last_ff  <= pop_data[0];
      end
      if (s1_adv) begin
         pixel_ff <= rom_data_ff;
         last_ff  <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.pixel_value = pixel_ff;
   assign rsp_if.last_pixel  = last_ff;

endmodule
`default_nettype wire

### hdl/phase_shift_fringe_generator.sv
// Path: a request accepted by the front stage passes the queue, the registered
// fringe ROM read and the response register before the response is valid.
// Throughput: one pixel per cycle while rsp_if.ready holds; the front stage,
// a 4-word queue and a two-stage back end (registered fringe ROM read,
// response register) each move one word per cycle.
// Reset: registers return to their defaults, position and phase clear,
// queue and back end empty. No clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// phase_shift_fringe_generator
// Phase-shifted sinusoidal fringe line generator, one pixel per unsuppressed word.
// ----------------------------------------------------------------------------
module phase_shift_fringe_generator import psfg_pkg::*; #(
   parameter int TABLE_BITS  = 10,
   parameter int PERIOD_BITS = 12
) (
   input  wire logic  clock,
   input  wire logic  reset,
   psfg_req_if.sink   req_if,
   psfg_rsp_if.source rsp_if,
   psfg_csr_if.sink   csr_if
);

   psfg_cfg_type      cfg;
   logic              push_valid;
   logic              push_ready;
   logic [TABLE_BITS:0] push_data;
   logic              pop_valid;
   logic              pop_ready;
   logic [TABLE_BITS:0] pop_data;

   psfg_regs #(
      .PERIOD_BITS (PERIOD_BITS)
   ) u_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   psfg_front #(
      .TABLE_BITS  (TABLE_BITS),
      .PERIOD_BITS (PERIOD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .cfg        (cfg),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   psfg_fifo #(
      .WIDTH (TABLE_BITS + 1)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   psfg_back #(
      .TABLE_BITS (TABLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_if    (rsp_if)
   );

endmodule
`default_nettype wire
